// ===== hdl/frp_pkg.sv =====
`timescale 1ns / 1ps
// frp_pkg: shared types and constants of the fen record parser
// no dependencies; imported by fen_record_parser and fen_record_parser_tb

package frp_pkg;

  // width of the move counters, saturating at all ones
  localparam int unsigned COUNTER_WIDTH = 16;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  // register indexes
  localparam logic REG_ARMY  = 1'b0;
  localparam logic REG_PIECE = 1'b1;

  // army_select codes
  localparam logic [1:0] ARMY_WHITE = 2'd0;
  localparam logic [1:0] ARMY_BLACK = 2'd1;
  localparam logic [1:0] ARMY_BOTH  = 2'd2;

  // piece_select codes beyond the single piece kinds
  localparam logic [2:0] PIECE_ALL  = 3'd6;
  localparam logic [2:0] PIECE_NONE = 3'd7;

  // side to move codes
  localparam logic [1:0] SIDE_WHITE = 2'd0;
  localparam logic [1:0] SIDE_BLACK = 2'd1;
  localparam logic [1:0] SIDE_NONE  = 2'd2;

  // field numbers
  localparam logic [2:0] FLD_PLACE  = 3'd0;
  localparam logic [2:0] FLD_SIDE   = 3'd1;
  localparam logic [2:0] FLD_CASTLE = 3'd2;
  localparam logic [2:0] FLD_PASS   = 3'd3;
  localparam logic [2:0] FLD_HALF   = 3'd4;
  localparam logic [2:0] FLD_FULL   = 3'd5;
  localparam logic [2:0] FLD_EXTRA  = 3'd6;

  localparam logic [7:0] CELL_START = 8'd56;
  localparam int unsigned NUM_KINDS = 6;

  // white piece letters by piece_select code; black is the lower case letter
  localparam logic [7:0] WHITE_PIECES [NUM_KINDS] = '{"K", "Q", "B", "N", "R", "P"};
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } fen_in_t;

  typedef struct packed {
    logic [63:0]              placement_board;
    logic [1:0]               side_to_move;
    logic [63:0]              castle_board;
    logic [63:0]              passant_board;
    logic [COUNTER_WIDTH-1:0] halfmove_clock;
    logic [COUNTER_WIDTH-1:0] fullmove_number;
  } fen_out_t;

endpackage

// ===== hdl/fen_record_parser.sv =====
`timescale 1ns / 1ps
// fen_record_parser: streaming parser of fen chess records, one character per transfer
// depends on frp_pkg for the payload types and code constants
//
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): one character per transfer,
//     last_char marks the final character of a record.
//   out channel (out_valid_o / out_stall_i / out_data_o): one result per record,
//     the boards, side to move and both move counters.
//   APB port: army_select at byte address 0, piece_select at 4. Write them only
//     while no record is in flight.
// Timing: one character is taken every cycle. The result of a record appears in
//   the output register in the cycle after its last character is taken. Characters
//   that do not end a record are always taken; a last character is held off
//   only while an earlier result still sits in the output register and the
//   receiver stalls, so a stalled receiver holds off no input until the next
//   record ends.
// Reset: parser state returns to the start of a record, army_select to both
//   armies, piece_select to all pieces, and the output register empties. After
//   each result the parser clears itself the same way, keeping the registers.

module fen_record_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  frp_pkg::fen_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output frp_pkg::fen_out_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [frp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [frp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import frp_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;

  // configuration
  logic [1:0] army_q;
  logic [2:0] piece_q;

  // parser state
  logic [2:0]    field_q, field_d;
  logic          gap_q, gap_d;
  logic [7:0]    cell_q, cell_d;
  logic [63:0]   place_q, place_d;
  logic [63:0]   castle_q, castle_d;
  logic [1:0]    side_q, side_d;
  logic [1:0]    len_q, len_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    second_q, second_d;
  logic [63:0]   pass_q, pass_d;
  logic [CW-1:0] half_q, half_d;
  logic [CW-1:0] full_q, full_d;
  logic          stop_q, stop_d;

  // output register
  logic     out_valid_q;
  fen_out_t out_q;
  fen_out_t res;

  logic       in_accept;
  logic       cfg_write;
  logic [7:0] c;
  logic       is_space;
  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic       piece_hit;
  logic       close_now;
  logic [2:0] rank;
  logic [2:0] file;

  function automatic logic [CW-1:0] counter_add(input logic [CW-1:0] acc,
                                                input logic [7:0] ch);
    logic [CW+3:0] wide;
    logic [CW+3:0] v;
    wide = {4'b0, acc};
    v = (wide << 3) + (wide << 1) + {{CW{1'b0}}, ch[3:0]};
    if (v > {4'b0, {CW{1'b1}}}) begin
      return {CW{1'b1}};
    end
    return v[CW-1:0];
  endfunction

  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = in_data_i.last_char & out_valid_q & out_stall_i;
  assign c = in_data_i.char_code;

  assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign is_digit = (c >= "0") && (c <= "9");

  always_comb begin
    is_upper = 1'b0;
    is_lower = 1'b0;
    for (int i = 0; i < NUM_KINDS; i++) begin
      is_upper = is_upper | (c == WHITE_PIECES[i]);
      is_lower = is_lower | (c == (WHITE_PIECES[i] | CASE_BIT));
    end
  end

  always_comb begin
    piece_hit = 1'b0;
    if (army_q == ARMY_BOTH) begin
      piece_hit = is_upper | is_lower;
    end else if (army_q != ARMY_WHITE && army_q != ARMY_BLACK) begin
      piece_hit = 1'b0;
    end else if (piece_q == PIECE_NONE) begin
      piece_hit = 1'b0;
    end else if (piece_q == PIECE_ALL) begin
      piece_hit = (army_q == ARMY_WHITE) ? is_upper : is_lower;
    end else if (army_q == ARMY_WHITE) begin
      piece_hit = (c == WHITE_PIECES[piece_q]);
    end else begin
      piece_hit = (c == (WHITE_PIECES[piece_q] | CASE_BIT));
    end
  end

  always_comb begin
    field_d  = field_q;
    gap_d    = gap_q;
    cell_d   = cell_q;
    place_d  = place_q;
    castle_d = castle_q;
    side_d   = side_q;
    len_d    = len_q;
    first_d  = first_q;
    second_d = second_q;
    pass_d   = pass_q;
    half_d   = half_q;
    full_d   = full_q;
    stop_d   = stop_q;
    rank     = second_q[2:0] - 3'd1;
    file     = first_q[2:0] - 3'd1;

    if (is_space) begin
      if (!gap_q && len_q != 2'd0) begin
        gap_d = 1'b1;
      end
    end else begin
      // first character of a new field
      if (gap_q) begin
        if (field_q < FLD_EXTRA) begin
          field_d = field_q + 3'd1;
        end
        gap_d    = 1'b0;
        len_d    = 2'd0;
        first_d  = 8'd0;
        second_d = 8'd0;
        stop_d   = 1'b0;
      end
      case (field_d)
        FLD_PLACE: begin
          if (c == "/") begin
            cell_d = cell_q - 8'd16;
          end else if (piece_hit) begin
            if (cell_q < 8'd64) begin
              place_d = place_q | (64'd1 << cell_q[5:0]);
            end
            cell_d = cell_q + 8'd1;
          end else if (c >= "1" && c <= "8") begin
            // low nibble of '1'..'8' is the skip count
            cell_d = cell_q + {4'b0, c[3:0]};
          end else begin
            cell_d = cell_q + 8'd1;
          end
        end
        FLD_CASTLE: begin
          if (c == "Q") castle_d[2]  = 1'b1;
          if (c == "K") castle_d[6]  = 1'b1;
          if (c == "q") castle_d[58] = 1'b1;
          if (c == "k") castle_d[62] = 1'b1;
        end
        FLD_HALF, FLD_FULL: begin
          if (!is_digit) begin
            stop_d = 1'b1;
          end else if (!stop_d) begin
            if (field_d == FLD_HALF) begin
              half_d = counter_add(half_q, c);
            end else begin
              full_d = counter_add(full_q, c);
            end
          end
        end
        default: ;
      endcase
      if (len_d == 2'd0) begin
        first_d = c;
      end else if (len_d == 2'd1) begin
        second_d = c;
      end
      if (len_d != 2'd3) begin
        len_d = len_d + 2'd1;
      end
    end

    close_now = is_space ? (!gap_q && len_q != 2'd0) : in_data_i.last_char;
    rank = second_d[2:0] - 3'd1;
    file = first_d[2:0] - 3'd1;
    if (close_now) begin
      if (field_d == FLD_SIDE) begin
        if (len_d == 2'd1 && first_d == "w") begin
          side_d = SIDE_WHITE;
        end else if (len_d == 2'd1 && first_d == "b") begin
          side_d = SIDE_BLACK;
        end else begin
          side_d = SIDE_NONE;
        end
      end else if (field_d == FLD_PASS) begin
        if (len_d == 2'd2 && first_d >= "a" && first_d <= "h" &&
            second_d >= "1" && second_d <= "8") begin
          pass_d = 64'd1 << {rank, file};
        end else begin
          pass_d = 64'd0;
        end
      end
    end

    res.placement_board = place_d;
    res.side_to_move    = side_d;
    res.castle_board    = castle_d;
    res.passant_board   = pass_d;
    res.halfmove_clock  = half_d;
    res.fullmove_number = full_d;

    // a finished record leaves the parser at its start state
    if (in_data_i.last_char) begin
      field_d  = FLD_PLACE;
      gap_d    = 1'b0;
      cell_d   = CELL_START;
      place_d  = 64'd0;
      castle_d = 64'd0;
      side_d   = SIDE_NONE;
      len_d    = 2'd0;
      first_d  = 8'd0;
      second_d = 8'd0;
      pass_d   = 64'd0;
      half_d   = '0;
      full_d   = '0;
      stop_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q  <= FLD_PLACE;
      gap_q    <= 1'b0;
      cell_q   <= CELL_START;
      place_q  <= 64'd0;
      castle_q <= 64'd0;
      side_q   <= SIDE_NONE;
      len_q    <= 2'd0;
      first_q  <= 8'd0;
      second_q <= 8'd0;
      pass_q   <= 64'd0;
      half_q   <= '0;
      full_q   <= '0;
      stop_q   <= 1'b0;
    end else if (in_accept) begin
      field_q  <= field_d;
      gap_q    <= gap_d;
      cell_q   <= cell_d;
      place_q  <= place_d;
      castle_q <= castle_d;
      side_q   <= side_d;
      len_q    <= len_d;
      first_q  <= first_d;
      second_q <= second_d;
      pass_q   <= pass_d;
      half_q   <= half_d;
      full_q   <= full_d;
      stop_q   <= stop_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && in_data_i.last_char) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_data_i.last_char) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      army_q  <= ARMY_BOTH;
      piece_q <= PIECE_ALL;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ARMY:  army_q  <= pwdata[1:0];
        REG_PIECE: piece_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ARMY:  prdata = {{(APB_DATA_W-2){1'b0}}, army_q};
      REG_PIECE: prdata = {{(APB_DATA_W-3){1'b0}}, piece_q};
      default:   prdata = '0;
    endcase
  end

  // a taken last character always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last_char |=> out_valid_o)
    else $error("no result after last character");

  // the parser is back at its start state after a record
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last_char |=>
      field_q == FLD_PLACE && cell_q == CELL_START && len_q == 2'd0 && !gap_q)
    else $error("parser not cleared after record");

  // input is held off only for a pending result behind a stalled receiver
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

  a_pass_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pass_q))
    else $error("more than one en passant square");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= FLD_EXTRA)
    else $error("field number out of range");

endmodule

// ===== tb/sv/fen_record_parser_tb.sv =====
`timescale 1ns / 1ps
// fen_record_parser_tb: self-checking bench that streams fen records into the parser
// and checks every result against a built-in predictor, over several register settings
// depends on frp_pkg and fen_record_parser

module fen_record_parser_tb;
  import frp_pkg::*;

  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned CHARS_PER_PHASE = 125;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned QUIET_LIMIT     = 5000;

  localparam logic [2:0] PIECE_KING   = 3'd0;
  localparam logic [2:0] PIECE_QUEEN  = 3'd1;
  localparam logic [2:0] PIECE_BISHOP = 3'd2;
  localparam logic [2:0] PIECE_KNIGHT = 3'd3;
  localparam logic [2:0] PIECE_ROOK   = 3'd4;
  localparam logic [2:0] PIECE_PAWN   = 3'd5;

  localparam logic [APB_ADDR_W-1:0] ADDR_ARMY  = {REG_ARMY, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_PIECE = {REG_PIECE, 2'b00};

  localparam logic [63:0] COUNTER_LIMIT = (64'd1 << COUNTER_WIDTH) - 64'd1;
  localparam logic [7:0]  WS_CODES [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

  localparam logic [1:0] PHASE_ARMY [NUM_PHASES] = '{
    ARMY_BOTH, ARMY_WHITE, ARMY_BLACK, ARMY_WHITE, ARMY_BLACK,
    ARMY_BOTH, ARMY_WHITE, ARMY_BLACK, ARMY_WHITE, ARMY_BLACK};
  localparam logic [2:0] PHASE_PIECE [NUM_PHASES] = '{
    PIECE_ALL, PIECE_KING, PIECE_PAWN, PIECE_ALL, PIECE_QUEEN,
    PIECE_NONE, PIECE_NONE, PIECE_BISHOP, PIECE_ROOK, PIECE_KNIGHT};

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  fen_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  fen_out_t              out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fen_record_parser uut (.*);

  fen_in_t     char_queue[$];
  fen_out_t    expected_results[$];
  logic [7:0]  record_text[$];
  int unsigned phase_chars;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // register copies as the parser sees them
  logic [1:0] army_cfg  = ARMY_BOTH;
  logic [2:0] piece_cfg = PIECE_ALL;

  // parser state mirror
  logic [2:0]               field_idx;
  logic                     between_fields;
  logic [7:0]               cell_pos;
  logic [63:0]              piece_squares;
  logic [63:0]              castle_squares;
  logic [63:0]              passant_squares;
  logic [1:0]               side;
  logic [1:0]               field_len;
  logic [7:0]               char0;
  logic [7:0]               char1;
  logic [COUNTER_WIDTH-1:0] halfmove;
  logic [COUNTER_WIDTH-1:0] fullmove;
  logic                     digits_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic restart_record();
    field_idx       = FLD_PLACE;
    between_fields  = 1'b0;
    cell_pos        = CELL_START;
    piece_squares   = '0;
    castle_squares  = '0;
    passant_squares = '0;
    side            = SIDE_NONE;
    field_len       = 2'd0;
    char0           = 8'd0;
    char1           = 8'd0;
    halfmove        = '0;
    fullmove        = '0;
    digits_done     = 1'b0;
  endtask

  function automatic logic piece_selected(logic [7:0] c);
    string uppers;
    string lowers;
    logic  is_upper;
    logic  is_lower;
    uppers   = "KQBNRP";
    lowers   = "kqbnrp";
    is_upper = 1'b0;
    is_lower = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (c == uppers[k]) is_upper = 1'b1;
      if (c == lowers[k]) is_lower = 1'b1;
    end
    if (army_cfg == ARMY_BOTH) return is_upper || is_lower;
    if (army_cfg > ARMY_BLACK || piece_cfg == PIECE_NONE) return 1'b0;
    if (piece_cfg == PIECE_ALL) return (army_cfg == ARMY_WHITE) ? is_upper : is_lower;
    if (army_cfg == ARMY_WHITE) return c == uppers[piece_cfg];
    return c == lowers[piece_cfg];
  endfunction

  function automatic logic [COUNTER_WIDTH-1:0] add_digit(logic [COUNTER_WIDTH-1:0] acc,
                                                         logic [7:0] c);
    logic [63:0] sum;
    sum = 64'(acc);
    sum = sum * 64'd10 + {56'd0, c - 8'h30};
    return (sum > COUNTER_LIMIT) ? COUNTER_LIMIT[COUNTER_WIDTH-1:0] : sum[COUNTER_WIDTH-1:0];
  endfunction

  task automatic close_field();
    if (field_idx == FLD_SIDE) begin
      if (field_len == 2'd1 && char0 == "w") side = SIDE_WHITE;
      else if (field_len == 2'd1 && char0 == "b") side = SIDE_BLACK;
      else side = SIDE_NONE;
    end else if (field_idx == FLD_PASS) begin
      passant_squares = '0;
      if (field_len == 2'd2 && char0 >= "a" && char0 <= "h" && char1 >= "1" && char1 <= "8")
        passant_squares[{char1[2:0] - 3'd1, char0[2:0] - 3'd1}] = 1'b1;
    end
  endtask

  // advances the mirror by one accepted character, queues the result on the last one
  task automatic parse_char(input fen_in_t item);
    logic [7:0] c;
    fen_out_t   rec;
    c = item.char_code;
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
      if (!between_fields && field_len != 2'd0) begin
        close_field();
        between_fields = 1'b1;
      end
    end else begin
      if (between_fields) begin
        if (field_idx < FLD_EXTRA) field_idx = field_idx + 3'd1;
        between_fields = 1'b0;
        field_len      = 2'd0;
        char0          = 8'd0;
        char1          = 8'd0;
        digits_done    = 1'b0;
      end
      case (field_idx)
        FLD_PLACE: begin
          if (c == "/") begin
            cell_pos = cell_pos - 8'd16;
          end else begin
            if (piece_selected(c)) begin
              if (cell_pos < 8'd64) piece_squares[cell_pos[5:0]] = 1'b1;
            end else if (c >= "1" && c <= "8") begin
              cell_pos = cell_pos + (c - 8'h31);
            end
            cell_pos = cell_pos + 8'd1;
          end
        end
        FLD_CASTLE: begin
          case (c)
            "Q":     castle_squares[2]  = 1'b1;
            "K":     castle_squares[6]  = 1'b1;
            "q":     castle_squares[58] = 1'b1;
            "k":     castle_squares[62] = 1'b1;
            default: ;
          endcase
        end
        FLD_HALF, FLD_FULL: begin
          if (c < "0" || c > "9") begin
            digits_done = 1'b1;
          end else if (!digits_done) begin
            if (field_idx == FLD_HALF) halfmove = add_digit(halfmove, c);
            else fullmove = add_digit(fullmove, c);
          end
        end
        default: ;
      endcase
      if (field_len == 2'd0) char0 = c;
      else if (field_len == 2'd1) char1 = c;
      if (field_len < 2'd3) field_len = field_len + 2'd1;
    end
    if (item.last_char) begin
      if (!between_fields && field_len != 2'd0) close_field();
      rec.placement_board = piece_squares;
      rec.side_to_move    = side;
      rec.castle_board    = castle_squares;
      rec.passant_board   = passant_squares;
      rec.halfmove_clock  = halfmove;
      rec.fullmove_number = fullmove;
      expected_results.push_back(rec);
      restart_record();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_record(input fen_out_t want, input fen_out_t got);
    check_field("placement_board", want.placement_board, got.placement_board);
    check_field("side_to_move", 64'(want.side_to_move), 64'(got.side_to_move));
    check_field("castle_board", want.castle_board, got.castle_board);
    check_field("passant_board", want.passant_board, got.passant_board);
    check_field("halfmove_clock", 64'(want.halfmove_clock), 64'(got.halfmove_clock));
    check_field("fullmove_number", 64'(want.fullmove_number), 64'(got.fullmove_number));
  endtask

  // character driver: holds a stalled transfer, otherwise offers the next queued character or goes idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_record();
    end else begin
      if (in_valid_i && !in_stall_o) parse_char(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= char_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        end else begin
          check_record(expected_results.pop_front(), out_data_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_config(input logic [1:0] army, input logic [2:0] piece);
    write_reg(ADDR_ARMY, APB_DATA_W'(army));
    write_reg(ADDR_PIECE, APB_DATA_W'(piece));
    army_cfg  = army;
    piece_cfg = piece;
  endtask

  task automatic wait_drained();
    while (char_queue.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic append(input string s);
    for (int i = 0; i < s.len(); i++) record_text.push_back(s[i]);
  endtask

  task automatic add_gap();
    repeat ($urandom_range(2, 1)) record_text.push_back(WS_CODES[$urandom_range(5)]);
  endtask

  function automatic logic [7:0] placement_char();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(255));
      1, 2, 3: return pick("12345678");
      default: return pick("KQBNRPkqbnrp");
    endcase
  endfunction

  // mostly well-formed records with random content, some truncated, padded or pure noise
  task automatic build_record();
    int unsigned fields;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 1)) record_text.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) add_gap();
    for (int r = $urandom_range(9); r >= 0; r--) begin
      repeat ($urandom_range(3)) record_text.push_back(placement_char());
      if (r > 0) record_text.push_back("/");
    end
    fields = ($urandom_range(5) == 0) ? $urandom_range(8) : 5;
    for (int f = 1; f <= fields; f++) begin
      add_gap();
      case (f)
        1: begin
          if ($urandom_range(4) != 0) record_text.push_back(pick("wb"));
          else repeat ($urandom_range(3, 1)) record_text.push_back(pick("wbWB-x"));
        end
        2: begin
          if ($urandom_range(6) == 0) record_text.push_back("-");
          else repeat ($urandom_range(4, 1)) record_text.push_back(pick("KQkqKQkq-x"));
        end
        3: begin
          if ($urandom_range(4) == 0) begin
            record_text.push_back("-");
          end else if ($urandom_range(3) != 0) begin
            record_text.push_back(pick("abcdefgh"));
            record_text.push_back(pick("12345678"));
          end else begin
            repeat ($urandom_range(3, 1)) record_text.push_back(pick("`aehi0189-"));
          end
        end
        4, 5: begin
          if ($urandom_range(7) == 0) record_text.push_back(pick("-x+"));
          repeat ($urandom_range(6, 1)) record_text.push_back(pick("0123456789"));
          if ($urandom_range(7) == 0) begin
            record_text.push_back(pick("-x."));
            record_text.push_back(pick("0123456789"));
          end
        end
        default: repeat ($urandom_range(3, 1)) record_text.push_back(pick("0123456789abcKq/"));
      endcase
    end
    if ($urandom_range(4) == 0) add_gap();
  endtask

  task automatic queue_record();
    fen_in_t item;
    for (int i = 0; i < record_text.size(); i++) begin
      item.char_code = record_text[i];
      item.last_char = (i == record_text.size() - 1);
      char_queue.push_back(item);
    end
    phase_chars += record_text.size();
    record_text.delete();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_config(PHASE_ARMY[p], PHASE_PIECE[p]);
      end
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_chars = 0;
      if (p == 0) begin
        // leading whitespace, rank drop, saturating clock, non-numeric move number
        append(" \tk/p w Qq a3 99999 x");
        queue_record();
        // piece past the end of the rank lands off the board
        append("8P b");
        queue_record();
      end
      while (phase_chars < CHARS_PER_PHASE) begin
        build_record();
        queue_record();
        if (p == PRESSURE_PHASE) wait_drained();
      end
    end
    wait_drained();
    if (mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
